// ----- rtl/ps2_mouse_packet_cursor_core_defines.svh -----
// ---------------------------------------------------------------------------
// ps2 mouse packet cursor core assertion macros
// shared concurrent assertion wrappers clocked on clock
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH

// assertion that is switched off while reset is high
`define PS2MPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// assertion that also holds across reset
`define PS2MPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/ps2mpc_pkg.sv -----
// ---------------------------------------------------------------------------
// ps2mpc_pkg
// types and constants of the ps2 mouse packet cursor core
// ---------------------------------------------------------------------------
`default_nettype none

package ps2mpc_pkg;

   // request function codes
   localparam logic FUNC_BYTE     = 1'b0;
   localparam logic FUNC_ACTIVATE = 1'b1;

   // event kinds
   localparam logic [1:0] EVENT_MOVE    = 2'd0;
   localparam logic [1:0] EVENT_PRESS   = 2'd1;
   localparam logic [1:0] EVENT_RELEASE = 2'd2;

   // register index, taken from paddr bit 2
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] WIDTH_RESET  = 8'd80;
   localparam logic [7:0] HEIGHT_RESET = 8'd25;

   // packet byte index of the next expected byte
   localparam logic [1:0] POS_HEAD  = 2'd0;
   localparam logic [1:0] POS_DELTA = 2'd1;

   typedef struct packed {
      logic [7:0] width;
      logic [7:0] height;
   } screen_type;

   typedef struct packed {
      logic              move;
      logic [2:0]        changed;
      logic [2:0]        was_down;
      logic signed [7:0] dx;
      logic signed [8:0] dy;
      logic [7:0]        cx;
      logic [7:0]        cy;
   } event_set_type;

endpackage

`default_nettype wire

// ----- rtl/ps2mpc_if.sv -----
// ---------------------------------------------------------------------------
// ps2mpc request and response channels
// valid/ready channels carrying mouse bytes in and cursor events out
// ---------------------------------------------------------------------------
`default_nettype none

interface ps2mpc_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic       aux_data_ready;
   logic [7:0] data_byte;

   modport source (output valid, output func, output aux_data_ready, output data_byte,
                   input ready);
   modport sink   (input valid, input func, input aux_data_ready, input data_byte,
                   output ready);
endinterface

interface ps2mpc_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        event_kind;
   logic [1:0]        button_number;
   logic signed [7:0] delta_x;
   logic signed [8:0] delta_y;
   logic [7:0]        cursor_x;
   logic [7:0]        cursor_y;
   logic              last_event;

   modport source (output valid, output event_kind, output button_number,
                   output delta_x, output delta_y, output cursor_x, output cursor_y,
                   output last_event, input ready);
   modport sink   (input valid, input event_kind, input button_number,
                   input delta_x, input delta_y, input cursor_x, input cursor_y,
                   input last_event, output ready);
endinterface

`default_nettype wire

// ----- rtl/ps2_mouse_packet_cursor_core.sv -----
// ---------------------------------------------------------------------------
// ps2_mouse_packet_cursor_core
// three-byte ps2 mouse packet decoder driving a clamped text cursor
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake            carries
//   req_chan  in         valid/ready          func, aux_data_ready, data_byte
//   rsp_chan  out        valid/ready          one move/press/release event
//   csr_*     in/out     apb, pready tied 1   screen_width @0, screen_height @4
//
// a request is taken in the cycle it is offered whenever the event queue is empty
// or its last pending event leaves in that cycle
// a packet-completing byte yields up to four events (0 to 4), one per cycle while rsp is ready
// rsp stalls simply hold the queue; req is held off only while events still wait
// synchronous reset: empty queue, packet restarts, buttons up, cursor at 40,12
//
`default_nettype none

module ps2_mouse_packet_cursor_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ps2mpc_req_if.sink                             req_chan,
   ps2mpc_rsp_if.source                           rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ps2mpc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ps2mpc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [ps2mpc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                              csr_pready
);

   // screen size to the decoder
   ps2mpc_pkg::screen_type    screen;
   // decoder to queue: one packet worth of events
   ps2mpc_pkg::event_set_type set;
   logic                      push;
   logic                      space;

   ps2mpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .screen  (screen)
   );

   // packet assembly and cursor math, registered into the queue
   ps2mpc_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .screen (screen),
      .space  (space),
      .push   (push),
      .set    (set)
   );

   // output register: drains move then buttons low to high
   ps2mpc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .set   (set),
      .space (space),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- rtl/ps2mpc_csr.sv -----
// ---------------------------------------------------------------------------
// ps2mpc_csr
// apb-style screen size registers
// ---------------------------------------------------------------------------
`default_nettype none

module ps2mpc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [ps2mpc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [ps2mpc_pkg::CSR_DATA_W-1:0]  pwdata,
   output      logic [ps2mpc_pkg::CSR_DATA_W-1:0]  prdata,
   output      logic                               pready,
   output      ps2mpc_pkg::screen_type             screen
);

   logic [7:0] width_ff;
   logic [7:0] height_ff;
   logic       wr_en;
   logic       reg_sel;
   logic [7:0] rd_val;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ps2mpc_pkg::WIDTH_RESET;
         height_ff <= ps2mpc_pkg::HEIGHT_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            ps2mpc_pkg::REG_WIDTH:  width_ff  <= pwdata[7:0];
            ps2mpc_pkg::REG_HEIGHT: height_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         ps2mpc_pkg::REG_WIDTH:  rd_val = width_ff;
         ps2mpc_pkg::REG_HEIGHT: rd_val = height_ff;
         default:                rd_val = 8'd0;
      endcase
   end

   assign prdata        = {{(ps2mpc_pkg::CSR_DATA_W-8){1'b0}}, rd_val};
   assign screen.width  = width_ff;
   assign screen.height = height_ff;

endmodule

`default_nettype wire

// ----- rtl/ps2mpc_decode.sv -----
// ---------------------------------------------------------------------------
// ps2mpc_decode
// packet assembly, cursor update and button diff in one pass
// ---------------------------------------------------------------------------
`default_nettype none

module ps2mpc_decode (
   input  wire logic                      clock,
   input  wire logic                      reset,
   ps2mpc_req_if.sink                     req,
   input  wire ps2mpc_pkg::screen_type    screen,
   input  wire logic                      space,
   output      logic                      push,
   output      ps2mpc_pkg::event_set_type set
);

   logic [1:0]        pos_ff, pos_in;
   logic [7:0]        head_ff, head_in;
   logic [7:0]        b1_ff, b1_in;
   logic [2:0]        buttons_ff, buttons_in;
   logic [7:0]        cx_ff, cx_in;
   logic [7:0]        cy_ff, cy_in;

   logic              accept;
   logic              byte_ok;
   logic              complete;
   logic              move;
   logic [2:0]        changed;
   logic signed [7:0] dx;
   logic signed [8:0] dy;
   logic [7:0]        x0, y0, x1, y1;

   // clamp to [0, size-1], zero size gives zero
   function automatic logic [7:0] clamp_axis(input logic signed [10:0] v,
                                             input logic [7:0] size);
      logic [7:0] r;
      if (v >= $signed({3'b000, size}))
         r = (size == 8'd0) ? 8'd0 : size - 8'd1;
      else if (v < 11'sd0)
         r = 8'd0;
      else
         r = v[7:0];
      return r;
   endfunction

   assign req.ready = space;
   assign accept    = req.valid && req.ready;
   assign byte_ok   = (req.func == ps2mpc_pkg::FUNC_BYTE) && req.aux_data_ready;
   assign complete  = byte_ok && pos_ff[1];

   assign dx      = $signed(b1_ff);
   assign dy      = -$signed({req.data_byte[7], req.data_byte});
   assign move    = (b1_ff != 8'd0) || (req.data_byte != 8'd0);
   assign changed = head_ff[2:0] ^ buttons_ff;

   assign x0 = clamp_axis($signed({3'b000, cx_ff}), screen.width);
   assign y0 = clamp_axis($signed({3'b000, cy_ff}), screen.height);
   assign x1 = clamp_axis($signed({3'b000, x0}) + {{3{dx[7]}}, dx}, screen.width);
   assign y1 = clamp_axis($signed({3'b000, y0}) + {{2{dy[8]}}, dy}, screen.height);

   assign push         = accept && complete && (move || (changed != 3'd0));
   assign set.move     = move;
   assign set.changed  = changed;
   assign set.was_down = buttons_ff;
   assign set.dx       = dx;
   assign set.dy       = dy;
   assign set.cx       = move ? x1 : cx_ff;
   assign set.cy       = move ? y1 : cy_ff;

   always_comb begin
      pos_in     = pos_ff;
      head_in    = head_ff;
      b1_in      = b1_ff;
      buttons_in = buttons_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      if (accept) begin
         if (req.func == ps2mpc_pkg::FUNC_ACTIVATE) begin
            pos_in     = ps2mpc_pkg::POS_HEAD;
            buttons_in = 3'd0;
            cx_in      = {1'b0, screen.width[7:1]};
            cy_in      = {1'b0, screen.height[7:1]};
         end else if (byte_ok) begin
            if (pos_ff[1]) begin
               pos_in     = ps2mpc_pkg::POS_HEAD;
               buttons_in = head_ff[2:0];
               if (move) begin
                  cx_in = x1;
                  cy_in = y1;
               end
            end else if (pos_ff == ps2mpc_pkg::POS_HEAD) begin
               head_in = req.data_byte;
               pos_in  = ps2mpc_pkg::POS_DELTA;
            end else begin
               b1_in  = req.data_byte;
               pos_in = pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= ps2mpc_pkg::POS_HEAD;
         buttons_ff <= 3'd0;
         cx_ff      <= {1'b0, ps2mpc_pkg::WIDTH_RESET[7:1]};
         cy_ff      <= {1'b0, ps2mpc_pkg::HEIGHT_RESET[7:1]};
      end else begin
         pos_ff     <= pos_in;
         buttons_ff <= buttons_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      b1_ff   <= b1_in;
   end

endmodule

`default_nettype wire

// ----- rtl/ps2mpc_queue.sv -----
// ---------------------------------------------------------------------------
// ps2mpc_queue
// holds one packet's pending events and hands them out one per cycle while rsp is ready
// ---------------------------------------------------------------------------
`default_nettype none

module ps2mpc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ps2mpc_pkg::event_set_type set,
   output      logic                      space,
   ps2mpc_rsp_if.source                   rsp
);

   logic              move_ff, move_in;
   logic [2:0]        changed_ff, changed_in;
   logic [2:0]        was_down_ff;
   logic signed [7:0] dx_ff;
   logic signed [8:0] dy_ff;
   logic [7:0]        cx_ff;
   logic [7:0]        cy_ff;

   logic [3:0]        pend;
   logic              single;
   logic              take;

   assign pend   = {changed_ff, move_ff};
   assign single = (pend != 4'd0) && ((pend & (pend - 4'd1)) == 4'd0);
   assign take   = rsp.valid && rsp.ready;
   assign space  = (pend == 4'd0) || (take && single);

   always_comb begin
      move_in    = move_ff;
      changed_in = changed_ff;
      if (push) begin
         move_in    = set.move;
         changed_in = set.changed;
      end else if (take) begin
         if (move_ff) move_in = 1'b0;
         else         changed_in = changed_ff & (changed_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_ff    <= 1'b0;
         changed_ff <= 3'd0;
      end else begin
         move_ff    <= move_in;
         changed_ff <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         was_down_ff <= set.was_down;
         dx_ff       <= set.dx;
         dy_ff       <= set.dy;
         cx_ff       <= set.cx;
         cy_ff       <= set.cy;
      end
   end

   // move first, then lowest changed button
   always_comb begin
      rsp.event_kind    = ps2mpc_pkg::EVENT_MOVE;
      rsp.button_number = 2'd0;
      rsp.delta_x       = 8'sd0;
      rsp.delta_y       = 9'sd0;
      if (move_ff) begin
         rsp.delta_x = dx_ff;
         rsp.delta_y = dy_ff;
      end else if (changed_ff[0]) begin
         rsp.button_number = 2'd1;
         rsp.event_kind    = was_down_ff[0] ? ps2mpc_pkg::EVENT_RELEASE
                                            : ps2mpc_pkg::EVENT_PRESS;
      end else if (changed_ff[1]) begin
         rsp.button_number = 2'd2;
         rsp.event_kind    = was_down_ff[1] ? ps2mpc_pkg::EVENT_RELEASE
                                            : ps2mpc_pkg::EVENT_PRESS;
      end else if (changed_ff[2]) begin
         rsp.button_number = 2'd3;
         rsp.event_kind    = was_down_ff[2] ? ps2mpc_pkg::EVENT_RELEASE
                                            : ps2mpc_pkg::EVENT_PRESS;
      end
   end

   assign rsp.valid      = pend != 4'd0;
   assign rsp.cursor_x   = cx_ff;
   assign rsp.cursor_y   = cy_ff;
   assign rsp.last_event = single;

endmodule

`default_nettype wire

// ----- rtl/ps2mpc_checker.sv -----
// ---------------------------------------------------------------------------
// ps2mpc_checker
// port-level assertions of the ps2 mouse packet cursor core
// ---------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_packet_cursor_core_defines.svh"

module ps2mpc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [1:0]        rsp_event_kind,
   input wire logic [1:0]        rsp_button_number,
   input wire logic signed [7:0] rsp_delta_x,
   input wire logic signed [8:0] rsp_delta_y,
   input wire logic [7:0]        rsp_cursor_x,
   input wire logic              rsp_last_event
);

   // stalled event keeps its contents
   `PS2MPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) && $stable(rsp_button_number) && $stable(rsp_cursor_x), "rsp changed while stalled")

   // more events of the same packet follow right away
   `PS2MPC_ASSERT(a_burst, rsp_valid && rsp_ready && !rsp_last_event |=> rsp_valid, "event burst broke before last")

   // button events carry no motion, move events name no button
   `PS2MPC_ASSERT(a_fields, rsp_valid |-> ((rsp_event_kind == ps2mpc_pkg::EVENT_MOVE) ? (rsp_button_number == 2'd0) : (rsp_button_number != 2'd0 && rsp_delta_x == 8'sd0 && rsp_delta_y == 9'sd0)), "event fields inconsistent")

   // nothing pending after reset
   `PS2MPC_ASSERT_ALWAYS(a_reset, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind ps2_mouse_packet_cursor_core ps2mpc_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_event_kind    (rsp_chan.event_kind),
   .rsp_button_number (rsp_chan.button_number),
   .rsp_delta_x       (rsp_chan.delta_x),
   .rsp_delta_y       (rsp_chan.delta_y),
   .rsp_cursor_x      (rsp_chan.cursor_x),
   .rsp_last_event    (rsp_chan.last_event)
);

`default_nettype wire
